// ===== src/ctsh_pkg.sv =====
// ctsh_pkg: shared types and constants of the crypt table string hash.
// Used by the fill engine, the mixer and the top level; depends on nothing.
`timescale 1ns / 1ps

package ctsh_pkg;

	// Seed start values
	localparam logic [31:0] SEED_ONE_INIT = 32'h7FED_7FED;
	localparam logic [31:0] SEED_TWO_INIT = 32'hEEEE_EEEE;

	// Table generator: s = (s * 125 + 3) mod 0x2AAAAB
	localparam int          LCG_W     = 22;
	localparam logic [21:0] LCG_START = 22'h10_0001;
	localparam logic [21:0] LCG_MOD   = 22'h2A_AAAB;
	localparam logic [21:0] LCG_INC   = 22'd3;
	localparam int          MUL_BITS  = 7;
	localparam logic [6:0]  LCG_MUL   = 7'd125;
	// Horner steps per generator value: one per multiplier bit plus the increment
	localparam logic [2:0]  STEP_LAST = 3'd7;

	localparam int ROW_WORDS = 256;
	localparam int BYTE_W    = 8;
	localparam int CHAR_W    = 16;
	localparam int HASH_W    = 32;

	// Lower-case range that is folded to upper case
	localparam logic [15:0] LOWER_A    = 16'h0061;
	localparam logic [15:0] LOWER_Z    = 16'h007A;
	localparam logic [15:0] CASE_DELTA = 16'h0020;

	// Configuration registers
	localparam int         CFG_INDEX_W   = 8;
	localparam int         CFG_DATA_W    = 3;
	localparam logic [7:0] REG_HASH_TYPE = 8'd0;
	localparam logic [7:0] REG_WIDE_MODE = 8'd1;

	// Result queue
	localparam int OQ_DEPTH = 4;
	localparam int OQ_PTR_W = 2;
	localparam int OQ_CNT_W = 3;

	// One operation for the mixer: a byte to mix or a string terminator
	typedef struct packed {
		logic              valid;
		logic              term;
		logic [BYTE_W-1:0] ch;
	} mix_op_t;

endpackage

// ===== src/crypt_table_string_hash.sv =====
// crypt_table_string_hash: streaming string hash over a crypt table RAM.
// Uses ctsh_pkg, ctsh_ram, ctsh_fill and ctsh_mix.
//
// Usage:
//  s_axis: one character per word; tdata = char_code, tlast = end of string
//  (the character of a tlast word is ignored and the hash is returned).
//  m_axis: one word per string, tdata = 32-bit hash.
//  cfg: write channel (cfg_index, cfg_data), always ready. Index 0 selects the
//  table row (hash_type), index 1 the 16-bit character mode. Write only when idle.
// Reset: the table RAM is filled by the generator, two values per table word;
//  s_axis_tready stays low until done. Seeds and registers are cleared at once.
// Throughput: one word per cycle in byte mode while s_axis_tready is high. A
//  16-bit character holds off the next word while its high byte is pending:
//  both bytes read the single RAM read port and go through the mixer.
// Output: a hash goes through the mix stage register, then the result queue, to m_axis.
// Stall: results wait in a four-word queue; s_axis_tready drops when the queue
//  with a result in flight is full, during the fill, and for a pending high byte.
`timescale 1ns / 1ps

module crypt_table_string_hash #(
	parameter int TABLE_KINDS = 5
) (
	input  logic        clk,
	input  logic        arst_n,
	// config write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_index,
	input  logic [2:0]  cfg_data,
	// character input
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // [15:0] char_code
	input  logic        s_axis_tlast,
	// hash output
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata   // [31:0] hash_value
);

	localparam int ROW_W  = (TABLE_KINDS > 1) ? $clog2(TABLE_KINDS) : 1;
	localparam int DEPTH  = TABLE_KINDS * ctsh_pkg::ROW_WORDS;
	localparam int ADDR_W = $clog2(DEPTH);

	// config registers
	logic [2:0] hash_type_q;
	logic       wide_mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_type_q <= '0;
			wide_mode_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == ctsh_pkg::REG_HASH_TYPE) begin
				hash_type_q <= cfg_data;
			end else if (cfg_index == ctsh_pkg::REG_WIDE_MODE) begin
				wide_mode_q <= cfg_data[0];
			end
		end
	end

	assign cfg_ready = 1'b1;

	// table fill
	logic                        fill_we;
	logic [ADDR_W-1:0]           fill_addr;
	logic [ctsh_pkg::HASH_W-1:0] fill_data;
	logic                        fill_done;

	ctsh_fill #(
		.TABLE_KINDS(TABLE_KINDS)
	) u_fill (
		.clk   (clk),
		.arst_n(arst_n),
		.we    (fill_we),
		.waddr (fill_addr),
		.wdata (fill_data),
		.done  (fill_done)
	);

	// front end: fold case, split bytes, form table addresses
	logic                        in_acc;
	logic [ctsh_pkg::CHAR_W-1:0] ch_raw;
	logic [ctsh_pkg::CHAR_W-1:0] ch_up;
	logic [ROW_W-1:0]            row;
	logic [ADDR_W-1:0]           lo_addr;
	logic [ADDR_W-1:0]           hi_addr;
	logic [ADDR_W-1:0]           rd_addr;
	logic                        hi_pending_q;
	logic [ADDR_W-1:0]           hi_addr_q;
	logic [ctsh_pkg::BYTE_W-1:0] hi_byte_q;

	assign in_acc = s_axis_tvalid && s_axis_tready;

	always_comb begin
		ch_raw = wide_mode_q ? s_axis_tdata : {8'h00, s_axis_tdata[7:0]};
		ch_up  = ch_raw;
		if (ch_raw >= ctsh_pkg::LOWER_A && ch_raw <= ctsh_pkg::LOWER_Z) begin
			ch_up = ch_raw - ctsh_pkg::CASE_DELTA;
		end
		// out-of-range hash types use the last row
		if (32'(hash_type_q) >= TABLE_KINDS) begin
			row = ROW_W'(TABLE_KINDS - 1);
		end else begin
			row = ROW_W'(hash_type_q);
		end
		lo_addr = ADDR_W'({row, ch_up[7:0]});
		hi_addr = ADDR_W'({row, ch_up[15:8]});
		rd_addr = hi_pending_q ? hi_addr_q : lo_addr;
	end

	// high byte of a wide character goes in the cycle after its low byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hi_pending_q <= 1'b0;
		end else begin
			hi_pending_q <= in_acc && wide_mode_q && !s_axis_tlast;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			hi_addr_q <= hi_addr;
			hi_byte_q <= ch_up[15:8];
		end
	end

	// table RAM
	logic [ctsh_pkg::HASH_W-1:0] tbl_word;

	ctsh_ram #(
		.WIDTH(ctsh_pkg::HASH_W),
		.DEPTH(DEPTH)
	) u_table (
		.clk  (clk),
		.we   (fill_we),
		.waddr(fill_addr),
		.wdata(fill_data),
		.raddr(rd_addr),
		.rdata(tbl_word)
	);

	// mix stage, aligned with the RAM read data
	ctsh_pkg::mix_op_t op_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_s1 <= '0;
		end else if (in_acc) begin
			op_s1.valid <= 1'b1;
			op_s1.term  <= s_axis_tlast;
			op_s1.ch    <= ch_up[7:0];
		end else if (hi_pending_q) begin
			op_s1.valid <= 1'b1;
			op_s1.term  <= 1'b0;
			op_s1.ch    <= hi_byte_q;
		end else begin
			op_s1.valid <= 1'b0;
			op_s1.term  <= 1'b0;
		end
	end

	logic                        res_valid;
	logic [ctsh_pkg::HASH_W-1:0] res_value;

	ctsh_mix u_mix (
		.clk      (clk),
		.arst_n   (arst_n),
		.op       (op_s1),
		.tbl_word (tbl_word),
		.res_valid(res_valid),
		.res_value(res_value)
	);

	// result queue
	logic [ctsh_pkg::HASH_W-1:0]   oq_mem_q [ctsh_pkg::OQ_DEPTH];
	logic [ctsh_pkg::OQ_PTR_W-1:0] oq_wr_q;
	logic [ctsh_pkg::OQ_PTR_W-1:0] oq_rd_q;
	logic [ctsh_pkg::OQ_CNT_W-1:0] oq_cnt_q;
	logic [ctsh_pkg::OQ_CNT_W-1:0] committed;
	logic                          oq_push;
	logic                          oq_pop;

	assign oq_push = res_valid;
	assign oq_pop  = m_axis_tvalid && m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oq_wr_q  <= '0;
			oq_rd_q  <= '0;
			oq_cnt_q <= '0;
		end else begin
			if (oq_push) begin
				oq_wr_q <= oq_wr_q + ctsh_pkg::OQ_PTR_W'(1);
			end
			if (oq_pop) begin
				oq_rd_q <= oq_rd_q + ctsh_pkg::OQ_PTR_W'(1);
			end
			oq_cnt_q <= oq_cnt_q + ctsh_pkg::OQ_CNT_W'(oq_push)
				- ctsh_pkg::OQ_CNT_W'(oq_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (oq_push) begin
			oq_mem_q[oq_wr_q] <= res_value;
		end
	end

	assign m_axis_tvalid = (oq_cnt_q != '0);
	assign m_axis_tdata  = oq_mem_q[oq_rd_q];

	// room for one more result beyond what is queued or in flight
	assign committed     = oq_cnt_q + ctsh_pkg::OQ_CNT_W'(res_valid);
	assign s_axis_tready = fill_done && !hi_pending_q
		&& (committed < ctsh_pkg::OQ_CNT_W'(ctsh_pkg::OQ_DEPTH));

`ifndef SYNTH
	// table is written only before the block takes characters
	a_fill_only: assert property (@(posedge clk) disable iff (!arst_n)
		fill_we |-> !fill_done)
		else $error("table write after fill done");

	// result queue never overflows
	a_oq_room: assert property (@(posedge clk) disable iff (!arst_n)
		(oq_push && oq_cnt_q == ctsh_pkg::OQ_CNT_W'(ctsh_pkg::OQ_DEPTH)) |-> oq_pop)
		else $error("result queue overflow");

	// a high-byte cycle follows a wide character word
	a_hi_follows: assert property (@(posedge clk) disable iff (!arst_n)
		hi_pending_q |-> $past(in_acc && wide_mode_q && !s_axis_tlast))
		else $error("stray high-byte cycle");

	// a terminator in the mixer leaves a result in the queue
	a_term_queued: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |=> (oq_cnt_q != '0))
		else $error("terminator result lost");
`endif

endmodule

// ===== src/ctsh_ram.sv =====
// ctsh_ram: generic single-write, single-read RAM with registered read data.
// Stand-alone; no package needed.
`timescale 1ns / 1ps

module ctsh_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1280,
	localparam int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

// ===== src/ctsh_fill.sv =====
// ctsh_fill: fills the crypt table after reset from the linear congruential
// sequence, one Horner step of the multiply-modulo per cycle. Uses ctsh_pkg.
`timescale 1ns / 1ps

module ctsh_fill #(
	parameter int TABLE_KINDS = 5,
	localparam int ROW_W = (TABLE_KINDS > 1) ? $clog2(TABLE_KINDS) : 1,
	localparam int ADDR_W = $clog2(TABLE_KINDS * ctsh_pkg::ROW_WORDS)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	output logic                        we,
	output logic [ADDR_W-1:0]           waddr,
	output logic [ctsh_pkg::HASH_W-1:0] wdata,
	output logic                        done
);

	logic [ctsh_pkg::LCG_W-1:0]  s_q;
	logic [ctsh_pkg::LCG_W-1:0]  r_q;
	logic [2:0]                  step_q;
	logic                        half_q;
	logic [15:0]                 hi_q;
	logic [ctsh_pkg::BYTE_W-1:0] col_q;
	logic [ROW_W-1:0]            row_q;
	logic                        done_q;

	logic [ctsh_pkg::LCG_W:0]   dbl;
	logic [ctsh_pkg::LCG_W-1:0] dbl_red;
	logic [ctsh_pkg::LCG_W-1:0] addend;
	logic [ctsh_pkg::LCG_W:0]   sum;
	logic [ctsh_pkg::LCG_W-1:0] sum_red;
	logic                       mul_bit;
	logic                       last_step;
	logic                       row_last;

	assign last_step = (step_q == ctsh_pkg::STEP_LAST);
	assign row_last  = (row_q == ROW_W'(TABLE_KINDS - 1));

	// one Horner step: r = 2r + bit*s (r taken as 0 on the first step), or r + 3 on the last step, both mod M
	always_comb begin
		mul_bit = 1'b0;
		if (!last_step) begin
			mul_bit = ctsh_pkg::LCG_MUL[3'(ctsh_pkg::MUL_BITS - 1) - step_q];
		end
		if (last_step) begin
			dbl = {1'b0, r_q};
		end else if (step_q == 3'd0) begin
			dbl = '0;
		end else begin
			dbl = {r_q, 1'b0};
		end
		dbl_red = (dbl >= {1'b0, ctsh_pkg::LCG_MOD}) ?
			ctsh_pkg::LCG_W'(dbl - {1'b0, ctsh_pkg::LCG_MOD}) : ctsh_pkg::LCG_W'(dbl);
		if (last_step) begin
			addend = ctsh_pkg::LCG_INC;
		end else if (mul_bit) begin
			addend = s_q;
		end else begin
			addend = '0;
		end
		sum = {1'b0, dbl_red} + {1'b0, addend};
		sum_red = (sum >= {1'b0, ctsh_pkg::LCG_MOD}) ?
			ctsh_pkg::LCG_W'(sum - {1'b0, ctsh_pkg::LCG_MOD}) : ctsh_pkg::LCG_W'(sum);
	end

	// sequencer over steps, halves, rows and columns
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_q    <= ctsh_pkg::LCG_START;
			r_q    <= '0;
			step_q <= '0;
			half_q <= 1'b0;
			hi_q   <= '0;
			col_q  <= '0;
			row_q  <= '0;
			done_q <= 1'b0;
		end else if (!done_q) begin
			r_q    <= sum_red;
			step_q <= step_q + 3'd1;
			if (last_step) begin
				s_q    <= sum_red;
				half_q <= !half_q;
				if (!half_q) begin
					hi_q <= sum_red[15:0];
				end else if (row_last) begin
					row_q <= '0;
					col_q <= col_q + ctsh_pkg::BYTE_W'(1);
					if (col_q == '1) begin
						done_q <= 1'b1;
					end
				end else begin
					row_q <= row_q + ROW_W'(1);
				end
			end
		end
	end

	// word goes out when its low half is ready
	assign we    = !done_q && last_step && half_q;
	assign waddr = ADDR_W'({row_q, col_q});
	assign wdata = {hi_q, sum_red[15:0]};
	assign done  = done_q;

endmodule

// ===== src/ctsh_mix.sv =====
// ctsh_mix: holds the two seeds and mixes one byte per cycle with the table
// word read for it; a terminator hands out the first seed. Uses ctsh_pkg.
`timescale 1ns / 1ps

module ctsh_mix (
	input  logic                        clk,
	input  logic                        arst_n,
	input  ctsh_pkg::mix_op_t           op,
	input  logic [ctsh_pkg::HASH_W-1:0] tbl_word,
	output logic                        res_valid,
	output logic [ctsh_pkg::HASH_W-1:0] res_value
);

	logic [ctsh_pkg::HASH_W-1:0] seed_one_q;
	logic [ctsh_pkg::HASH_W-1:0] seed_two_q;
	logic [ctsh_pkg::HASH_W-1:0] next_one;
	logic [ctsh_pkg::HASH_W-1:0] next_two;

	// seed_one = T ^ (s1 + s2); seed_two = ch + seed_one + 33*s2 + 3
	always_comb begin
		next_one = tbl_word ^ (seed_one_q + seed_two_q);
		next_two = ctsh_pkg::HASH_W'(op.ch) + next_one + seed_two_q
			+ {seed_two_q[ctsh_pkg::HASH_W-6:0], 5'b0} + 32'd3;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_one_q <= ctsh_pkg::SEED_ONE_INIT;
			seed_two_q <= ctsh_pkg::SEED_TWO_INIT;
		end else if (op.valid) begin
			if (op.term) begin
				seed_one_q <= ctsh_pkg::SEED_ONE_INIT;
				seed_two_q <= ctsh_pkg::SEED_TWO_INIT;
			end else begin
				seed_one_q <= next_one;
				seed_two_q <= next_two;
			end
		end
	end

	assign res_valid = op.valid && op.term;
	assign res_value = seed_one_q;

endmodule

// ===== sim/tb_crypt_table_string_hash.sv =====
// tb_crypt_table_string_hash: self-checking bench for the streaming string hash.
// Predicts each hash from its own copy of the crypt table and seeds; uses ctsh_pkg.
`timescale 1ns / 1ps

module tb_crypt_table_string_hash;

	localparam int TABLE_KINDS  = 5;
	localparam int TABLE_WORDS  = TABLE_KINDS * ctsh_pkg::ROW_WORDS;
	localparam int STALL_LIMIT  = 100000;  // covers the table fill after reset
	localparam int SETTLE_WAIT  = 8;
	localparam int PHASE_ITEMS  = 200;
	localparam int RAND_PHASES  = 8;
	localparam logic [31:0] GEN_STEP_ADD = 32'd3;

	typedef struct packed {
		logic [15:0] code;
		logic        last;
	} char_item_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [7:0]  cfg_index = '0;
	logic [2:0]  cfg_data = '0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata = '0;   // [15:0] char_code
	logic        s_axis_tlast = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;        // [31:0] hash_value

	// Predictor state
	logic [31:0] crypt_words [0:TABLE_WORDS-1];
	logic [31:0] acc_one;
	logic [31:0] acc_two;
	logic [2:0]  sel_row_reg;
	logic        wide_reg;

	char_item_t  pending_chars[$];
	logic [31:0] hash_expected[$];
	int          chars_queued = 0;
	int          chars_taken = 0;
	int          err_count = 0;
	int          quiet_cycles = 0;
	int          send_idle_pct = 0;
	int          recv_stall_pct = 0;
	logic        char_taken = 1'b0;
	logic        cfg_taken = 1'b0;

	crypt_table_string_hash #(.TABLE_KINDS(TABLE_KINDS)) uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// Build the crypt table: two generator steps per word, high half first, column-major
	function automatic logic [31:0] gen_next(input logic [31:0] s);
		return (s * ctsh_pkg::LCG_MUL + GEN_STEP_ADD) % ctsh_pkg::LCG_MOD;
	endfunction

	initial begin
		logic [31:0] gen;
		logic [31:0] upper;
		gen = 32'(ctsh_pkg::LCG_START);
		for (int col = 0; col < ctsh_pkg::ROW_WORDS; col++) begin
			for (int row = 0; row < TABLE_KINDS; row++) begin
				gen = gen_next(gen);
				upper = gen & 32'hFFFF;
				gen = gen_next(gen);
				crypt_words[row * ctsh_pkg::ROW_WORDS + col] =
					(upper << 16) | (gen & 32'hFFFF);
			end
		end
	end

	task report_mismatch(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("%0t mismatch: %s got %h expected %h", $realtime, what, got, want);
		err_count++;
	endtask

	// Mix one byte into the seeds using the selected row
	task fold_byte(input logic [7:0] b);
		int row;
		row = (sel_row_reg >= TABLE_KINDS) ? TABLE_KINDS - 1 : sel_row_reg;
		acc_one = crypt_words[row * ctsh_pkg::ROW_WORDS + b] ^ (acc_one + acc_two);
		acc_two = {24'd0, b} + acc_one + acc_two + (acc_two << 5) + GEN_STEP_ADD;
	endtask

	task predict_char(input logic [15:0] code, input logic last);
		logic [15:0] c;
		if (last) begin
			hash_expected.push_back(acc_one);
			acc_one = ctsh_pkg::SEED_ONE_INIT;
			acc_two = ctsh_pkg::SEED_TWO_INIT;
		end else begin
			c = wide_reg ? code : {8'h00, code[7:0]};
			if (c >= ctsh_pkg::LOWER_A && c <= ctsh_pkg::LOWER_Z)
				c = c - ctsh_pkg::CASE_DELTA;
			fold_byte(c[7:0]);
			if (wide_reg)
				fold_byte(c[15:8]);
		end
	endtask

	// Input driver: next word is taken from the queue once the current one is gone; also sets a random m_axis_tready
	always @(negedge clk) begin
		char_item_t nxt;
		if (arst_n && (!s_axis_tvalid || char_taken)) begin
			if (pending_chars.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
				nxt = pending_chars.pop_front();
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= nxt.code;
				s_axis_tlast <= nxt.last;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
		m_axis_tready <= ($urandom_range(99, 0) >= recv_stall_pct);
	end

	// Monitor: predict on accepted characters, check hashes, track config, watchdog
	always @(posedge clk) begin
		logic [31:0] want;
		char_taken = s_axis_tvalid && s_axis_tready;
		if (arst_n) begin
			quiet_cycles++;
			if (char_taken) begin
				predict_char(s_axis_tdata, s_axis_tlast);
				chars_taken++;
				quiet_cycles = 0;
			end
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == ctsh_pkg::REG_HASH_TYPE)
					sel_row_reg = cfg_data;
				else if (cfg_index == ctsh_pkg::REG_WIDE_MODE)
					wide_reg = cfg_data[0];
				cfg_taken = 1'b1;
				quiet_cycles = 0;
			end
			if (m_axis_tvalid && m_axis_tready) begin
				quiet_cycles = 0;
				if (hash_expected.size() == 0) begin
					report_mismatch("hash with none pending", m_axis_tdata, '0);
				end else begin
					want = hash_expected.pop_front();
					if (m_axis_tdata !== want)
						report_mismatch("hash_value", m_axis_tdata, want);
				end
			end
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("watchdog: no progress for %0d cycles", quiet_cycles);
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	task add_char(input logic [15:0] code, input logic last);
		pending_chars.push_back('{code: code, last: last});
		chars_queued++;
	endtask

	task write_reg(input logic [7:0] idx, input logic [2:0] val);
		@(negedge clk);
		cfg_taken = 1'b0;
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(negedge clk); while (!cfg_taken);
		cfg_valid <= 1'b0;
	endtask

	// Block is idle once every word is taken, every hash is back, and mixing has settled
	task wait_settled();
		while (chars_taken != chars_queued || hash_expected.size() != 0)
			@(negedge clk);
		repeat (SETTLE_WAIT) @(negedge clk);
	endtask

	// Random character: letters and case-fold edges mostly, full codes too
	function automatic logic [15:0] pick_char(input logic wide);
		logic [7:0] lo;
		logic [7:0] hi;
		int kind;
		kind = $urandom_range(9, 0);
		if (kind < 4) begin
			lo = 8'h61 + 8'($urandom_range(25, 0));
		end else if (kind < 6) begin
			lo = 8'($urandom_range(255, 0));
		end else if (kind < 8) begin
			case ($urandom_range(3, 0))
				0: lo = 8'h60;
				1: lo = 8'h7B;
				2: lo = 8'h41;
				default: lo = 8'h5A;
			endcase
		end else begin
			return 16'($urandom_range(16'hFFFF, 0));
		end
		hi = (wide && $urandom_range(1, 0) == 0) ? 8'h00 : 8'($urandom_range(255, 0));
		return {hi, lo};
	endfunction

	initial begin
		logic [2:0] row_plan [0:RAND_PHASES-1];
		logic       wide_plan [0:RAND_PHASES-1];
		int str_len;
		int added;
		row_plan  = '{3'd0, 3'd4, 3'd7, 3'd2, 3'd5, 3'd1, 3'd3, 3'd6};
		wide_plan = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0};

		acc_one = ctsh_pkg::SEED_ONE_INIT;
		acc_two = ctsh_pkg::SEED_TWO_INIT;
		sel_row_reg = '0;
		wide_reg = 1'b0;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;

		// Directed, byte mode at reset defaults
		add_char(16'h0000, 1'b1);             // empty string
		add_char(16'h0000, 1'b0);
		add_char(16'h00FF, 1'b0);
		add_char(16'h0061, 1'b0);
		add_char(16'h007A, 1'b0);
		add_char(16'h0060, 1'b0);
		add_char(16'h007B, 1'b0);
		add_char(16'hFF61, 1'b0);             // upper bits ignored in byte mode
		add_char(16'h1241, 1'b0);
		add_char(16'hFFFF, 1'b1);             // terminator character ignored
		add_char(16'h0041, 1'b0);
		add_char(16'h005A, 1'b0);
		add_char(16'h0080, 1'b0);
		add_char(16'h0000, 1'b1);
		add_char(16'h0062, 1'b0);             // left open across the mode change
		add_char(16'h0063, 1'b0);
		wait_settled();
		write_reg(ctsh_pkg::REG_WIDE_MODE, 3'b001);
		write_reg(ctsh_pkg::REG_HASH_TYPE, 3'd4);
		write_reg(8'd2, 3'd7);                // unused index, ignored
		add_char(16'h0061, 1'b0);
		add_char(16'h6100, 1'b0);             // no folding above the low byte
		add_char(16'hFFFF, 1'b0);
		add_char(16'h007A, 1'b0);
		add_char(16'h00FF, 1'b0);
		add_char(16'h7B00, 1'b0);
		add_char(16'h0000, 1'b1);
		add_char(16'h0000, 1'b1);             // empty string in wide mode
		wait_settled();

		// Random phases, each with its own setting; the idling pattern repeats every four phases
		for (int p = 0; p < RAND_PHASES; p++) begin
			write_reg(ctsh_pkg::REG_HASH_TYPE, row_plan[p]);
			write_reg(ctsh_pkg::REG_WIDE_MODE, {2'($urandom_range(3, 0)), wide_plan[p]});
			if ($urandom_range(1, 0) == 0)
				write_reg(8'($urandom_range(255, 2)), 3'($urandom_range(7, 0)));
			case (p % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 49; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 49; end
				default: begin send_idle_pct = 36; recv_stall_pct = 36; end
			endcase
			added = 0;
			while (added < PHASE_ITEMS) begin
				str_len = ($urandom_range(9, 0) == 0) ? $urandom_range(40, 13)
					: $urandom_range(12, 0);
				for (int i = 0; i < str_len; i++)
					add_char(pick_char(wide_plan[p]), 1'b0);
				add_char(16'($urandom_range(16'hFFFF, 0)), 1'b1);
				added += str_len + 1;
			end
			// sometimes leave a string open so the next setting applies mid-string
			if ($urandom_range(2, 0) == 0) begin
				add_char(pick_char(wide_plan[p]), 1'b0);
				add_char(pick_char(wide_plan[p]), 1'b0);
			end
			wait_settled();
		end

		send_idle_pct = 0;
		recv_stall_pct = 0;
		add_char(16'h0000, 1'b1);
		wait_settled();
		if (hash_expected.size() != 0)
			report_mismatch("hashes never returned", 32'(hash_expected.size()), '0);
		if (err_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
